// ===== src/rdcq_pkg.sv =====
// Shared types and constants of the range distinct-count query block.
`timescale 1ns / 1ps
`default_nettype none
package rdcq_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int VALUE_BITS_DEF = 32;
  localparam int ELEM_BITS      = 32;

  typedef enum logic [1:0] {
    ACT_RESTART = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_QUERY   = 2'd2
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_PAST  = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_APPEND = 2'd1,
    S_QUERY  = 2'd2
  } state_e;

  typedef struct packed {
    logic load;
    logic run;
    logic down;
    logic query;
  } scan_cmd_t;

  typedef struct packed {
    logic pend;
    logic last;
    logic hit;
  } scan_sts_t;

endpackage
`default_nettype wire

// ===== src/rdcq_mem.sv =====
// Single-port-write, single-port-read memory with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rdcq_mem #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== src/rdcq_scan.sv =====
// Shared scan unit: address walker, read pipeline, compare and hit counter.
`timescale 1ns / 1ps
`default_nettype none
module rdcq_scan
  import rdcq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int KW        = (VALUE_BITS < ELEM_BITS) ? VALUE_BITS : ELEM_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire scan_cmd_t     cmd_i,
  input  wire logic [AW-1:0] first_i,
  input  wire logic [AW-1:0] stop_i,
  input  wire logic [KW-1:0] key_i,
  input  wire logic [AW-1:0] left_i,
  input  wire logic [KW-1:0] val_rdata_i,
  input  wire logic [CW-1:0] prv_rdata_i,
  output logic      [AW-1:0] rd_addr_o,
  output logic      [AW-1:0] pend_addr_o,
  output logic      [CW-1:0] count_o,
  output scan_sts_t          sts_o
);

  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] stop_q, stop_d;
  logic [AW-1:0] pend_addr_q, pend_addr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          down_q, down_d;
  logic          query_q, query_d;
  logic          more_q, more_d;
  logic          pend_q, pend_d;
  logic          match;

  always_comb begin
    if (query_q) begin
      match = (prv_rdata_i == CW'(DEPTH)) || (prv_rdata_i < CW'(left_i));
    end else begin
      match = (val_rdata_i == key_i);
    end
  end

  assign sts_o.pend  = pend_q;
  assign sts_o.last  = pend_q && (pend_addr_q == stop_q);
  assign sts_o.hit   = pend_q && match;
  assign rd_addr_o   = addr_q;
  assign pend_addr_o = pend_addr_q;
  assign count_o     = cnt_q + CW'(sts_o.hit);

  always_comb begin
    addr_d      = addr_q;
    stop_d      = stop_q;
    down_d      = down_q;
    query_d     = query_q;
    more_d      = more_q;
    pend_d      = 1'b0;
    pend_addr_d = pend_addr_q;
    cnt_d       = cnt_q;
    if (cmd_i.load) begin
      addr_d  = first_i;
      stop_d  = stop_i;
      down_d  = cmd_i.down;
      query_d = cmd_i.query;
      more_d  = 1'b1;
      cnt_d   = '0;
    end else if (cmd_i.run) begin
      cnt_d = count_o;
      if (more_q) begin
        pend_d      = 1'b1;
        pend_addr_d = addr_q;
        if (addr_q == stop_q) begin
          more_d = 1'b0;
        end else if (down_q) begin
          addr_d = addr_q - AW'(1);
        end else begin
          addr_d = addr_q + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      more_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      more_q <= more_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q      <= addr_d;
    stop_q      <= stop_d;
    down_q      <= down_d;
    query_q     <= query_d;
    pend_addr_q <= pend_addr_d;
    cnt_q       <= cnt_d;
  end

endmodule
`default_nettype wire

// ===== src/range_distinct_count_query.sv =====
// Top level of the range distinct-count query block: sequencer and stores.
//
// Usage: an item is taken on a rising edge with start high and busy low.
// action_i selects restart (clear the loaded length, no result), append
// (store element_value_i, one result) or range query over
// [left_index_i, right_index_i] (one result). Action code 3 is ignored.
// Each result shows on distinct_count_o / status_o for exactly one cycle
// with strobe_o high; the receiver cannot stall it.
// An append to a non-empty store scans the stored values from the newest
// back to the nearest equal one, one entry per cycle through the value memory
// read port. A query reads one previous-match entry per cycle. Rejected items
// (store full, empty range, past loaded length) answer on the next cycle.
// busy stays high while a scan runs; the next item may start in the cycle
// its predecessor's result is shown.
// Reset clears the loaded length and the sequencer; memory contents are
// undefined until written and are never read before that.
`timescale 1ns / 1ps
`default_nettype none
module range_distinct_count_query
  import rdcq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  localparam int AW        = $clog2(DEPTH),
  localparam int CW        = $clog2(DEPTH + 1),
  localparam int KW        = (VALUE_BITS < ELEM_BITS) ? VALUE_BITS : ELEM_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic        [1:0]           action_i,
  input  wire logic signed [ELEM_BITS-1:0] element_value_i,
  input  wire logic        [AW-1:0]        left_index_i,
  input  wire logic        [AW-1:0]        right_index_i,
  output logic                             strobe_o,
  output logic             [CW-1:0]        distinct_count_o,
  output logic             [1:0]           status_o
);

  state_e        state_q, state_d;
  logic [CW-1:0] loaded_q, loaded_d;
  logic [KW-1:0] key_q, key_d;
  logic [AW-1:0] left_q, left_d;
  logic          strobe_q, strobe_d;
  logic [CW-1:0] count_q, count_d;
  status_e       status_q, status_d;

  scan_cmd_t     cmd;
  scan_sts_t     sts;
  logic [AW-1:0] first;
  logic [AW-1:0] stop;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] pend_addr;
  logic [CW-1:0] scan_count;
  logic [KW-1:0] val_rdata;
  logic [CW-1:0] prv_rdata;

  logic          we;
  logic [KW-1:0] val_wdata;
  logic [CW-1:0] prv_wdata;
  logic [KW-1:0] elem_key;

  assign elem_key = element_value_i[KW-1:0];

  always_comb begin
    state_d   = state_q;
    loaded_d  = loaded_q;
    key_d     = key_q;
    left_d    = left_q;
    strobe_d  = 1'b0;
    count_d   = count_q;
    status_d  = status_q;
    cmd       = '0;
    first     = left_index_i;
    stop      = right_index_i;
    we        = 1'b0;
    val_wdata = key_q;
    prv_wdata = CW'(DEPTH);
    case (state_q)
      S_IDLE: begin
        if (start) begin
          case (action_e'(action_i))
            ACT_RESTART: begin
              loaded_d = '0;
            end
            ACT_APPEND: begin
              if (loaded_q == CW'(DEPTH)) begin
                strobe_d = 1'b1;
                count_d  = '0;
                status_d = ST_FULL;
              end else if (loaded_q == '0) begin
                we        = 1'b1;
                val_wdata = elem_key;
                loaded_d  = loaded_q + CW'(1);
                strobe_d  = 1'b1;
                count_d   = '0;
                status_d  = ST_OK;
              end else begin
                key_d     = elem_key;
                first     = AW'(loaded_q - CW'(1));
                stop      = '0;
                cmd.load  = 1'b1;
                cmd.down  = 1'b1;
                state_d   = S_APPEND;
              end
            end
            ACT_QUERY: begin
              if (left_index_i > right_index_i) begin
                strobe_d = 1'b1;
                count_d  = '0;
                status_d = ST_EMPTY;
              end else if (CW'(right_index_i) >= loaded_q) begin
                strobe_d = 1'b1;
                count_d  = '0;
                status_d = ST_PAST;
              end else begin
                left_d    = left_index_i;
                cmd.load  = 1'b1;
                cmd.query = 1'b1;
                state_d   = S_QUERY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_APPEND: begin
        cmd.run = 1'b1;
        if (sts.hit || sts.last) begin
          we        = 1'b1;
          prv_wdata = sts.hit ? CW'(pend_addr) : CW'(DEPTH);
          loaded_d  = loaded_q + CW'(1);
          strobe_d  = 1'b1;
          count_d   = '0;
          status_d  = ST_OK;
          state_d   = S_IDLE;
        end
      end
      S_QUERY: begin
        cmd.run = 1'b1;
        if (sts.last) begin
          strobe_d = 1'b1;
          count_d  = scan_count;
          status_d = ST_OK;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      loaded_q <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      loaded_q <= loaded_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    left_q   <= left_d;
    count_q  <= count_d;
    status_q <= status_d;
  end

  rdcq_scan #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .first_i     (first),
    .stop_i      (stop),
    .key_i       (key_q),
    .left_i      (left_q),
    .val_rdata_i (val_rdata),
    .prv_rdata_i (prv_rdata),
    .rd_addr_o   (rd_addr),
    .pend_addr_o (pend_addr),
    .count_o     (scan_count),
    .sts_o       (sts)
  );

  rdcq_mem #(
    .WIDTH (KW),
    .DEPTH (DEPTH)
  ) u_val_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(loaded_q)),
    .wdata_i (val_wdata),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  rdcq_mem #(
    .WIDTH (CW),
    .DEPTH (DEPTH)
  ) u_prv_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (AW'(loaded_q)),
    .wdata_i (prv_wdata),
    .raddr_i (rd_addr),
    .rdata_o (prv_rdata)
  );

  assign busy             = (state_q != S_IDLE);
  assign strobe_o         = strobe_q;
  assign distinct_count_o = count_q;
  assign status_o         = status_q;

endmodule
`default_nettype wire

// ===== src/rdcq_checker.sv =====
// Port-level checker of the range distinct-count query block, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module rdcq_checker
  import rdcq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  localparam int AW   = $clog2(DEPTH),
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic [1:0]    action_i,
  input wire logic [AW-1:0] left_index_i,
  input wire logic [AW-1:0] right_index_i,
  input wire logic          strobe_o,
  input wire logic [CW-1:0] distinct_count_o,
  input wire logic [1:0]    status_o
);

  logic take;
  assign take = start && !busy;

  a_err_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o != ST_OK) |-> (distinct_count_o == '0))
    else $error("rejected item carries a nonzero count");

  a_restart_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (action_i == ACT_RESTART) |=> !strobe_o && !busy)
    else $error("restart produced a result or a busy cycle");

  a_empty_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && (action_i == ACT_QUERY) && (left_index_i > right_index_i)
      |=> strobe_o && (status_o == ST_EMPTY))
    else $error("empty range not flagged on the next cycle");

  a_strobe_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> !busy)
    else $error("result shown while a scan runs");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && (status_o == ST_OK) |-> (distinct_count_o <= CW'(DEPTH)))
    else $error("count beyond store depth");

endmodule

bind range_distinct_count_query rdcq_checker #(
  .DEPTH (DEPTH)
) u_rdcq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .action_i         (action_i),
  .left_index_i     (left_index_i),
  .right_index_i    (right_index_i),
  .strobe_o         (strobe_o),
  .distinct_count_o (distinct_count_o),
  .status_o         (status_o)
);
`default_nettype wire

// ===== dv/tb_range_distinct_count_query.sv =====
// Self-checking testbench of the range distinct-count query block.
`timescale 1ns / 1ps
module tb_range_distinct_count_query;
  import rdcq_pkg::*;

  localparam int DEPTH        = 1024;
  localparam int AW           = 10;
  localparam int CW           = 11;
  localparam int RAND_ITEMS   = 580;
  localparam int DIR_ROWS     = 25;
  localparam int DRAIN_CYCLES = 1100;
  localparam int LIMIT_NS     = 40_000_000;
  localparam int MAX_REPORTS  = 10;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef struct packed {
    logic [CW-1:0] count;
    status_e       status;
  } answer_t;

  typedef struct packed {
    logic [1:0]    act;
    logic [31:0]   val;
    logic [AW-1:0] lo;
    logic [AW-1:0] hi;
    logic          typed;
    answer_t       ans;
  } stim_row_t;

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 start           = 1'b0;
  logic [1:0]           action_i        = ACT_RESTART;
  logic signed [31:0]   element_value_i = '0;
  logic [AW-1:0]        left_index_i    = '0;
  logic [AW-1:0]        right_index_i   = '0;
  logic                 busy;
  logic                 strobe_o;
  logic [CW-1:0]        distinct_count_o;
  logic [1:0]           status_o;

  range_distinct_count_query #(
    .DEPTH     (DEPTH),
    .VALUE_BITS(32)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .action_i        (action_i),
    .element_value_i (element_value_i),
    .left_index_i    (left_index_i),
    .right_index_i   (right_index_i),
    .strobe_o        (strobe_o),
    .distinct_count_o(distinct_count_o),
    .status_o        (status_o)
  );

  logic [31:0] tb_values     [DEPTH];
  int          tb_prev_match [DEPTH];
  int          tb_loaded = 0;
  answer_t     pending_answers[$];
  int          fail_count = 0;
  int          results_checked = 0;
  int          quiet_items = 0;
  int          n_appends = 0, n_full = 0, n_counted = 0;
  int          n_empty = 0, n_past = 0, n_restarts = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("Timeout at %0t ns with %0d answers pending", $time, pending_answers.size());
    $display("Verification failed");
    $finish;
  end

  function automatic logic predict_answer(input logic [1:0] act, input logic [31:0] val,
                                          input logic [AW-1:0] lo, input logic [AW-1:0] hi,
                                          output answer_t ans);
    int prev;
    int hits;
    ans = '{count: '0, status: ST_OK};
    case (act)
      ACT_RESTART: begin
        tb_loaded = 0;
        n_restarts++;
        return 1'b0;
      end
      ACT_APPEND: begin
        if (tb_loaded >= DEPTH) begin
          ans.status = ST_FULL;
          n_full++;
          return 1'b1;
        end
        prev = DEPTH;
        for (int k = tb_loaded - 1; k >= 0; k--) begin
          if (tb_values[k] == val) begin
            prev = k;
            break;
          end
        end
        tb_values[tb_loaded]     = val;
        tb_prev_match[tb_loaded] = prev;
        tb_loaded++;
        n_appends++;
        return 1'b1;
      end
      ACT_QUERY: begin
        if (lo > hi) begin
          ans.status = ST_EMPTY;
          n_empty++;
        end else if (int'(hi) >= tb_loaded) begin
          ans.status = ST_PAST;
          n_past++;
        end else begin
          hits = 0;
          for (int p = int'(lo); p <= int'(hi); p++) begin
            if (tb_prev_match[p] == DEPTH || tb_prev_match[p] < int'(lo)) hits++;
          end
          ans.count = CW'(hits);
          n_counted++;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet_items > 0) begin
      quiet_items--;
      return 0;
    end
    if (r < 3) begin
      quiet_items = $urandom_range(10, 40);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 80);
  endfunction

  task automatic send_item(input logic [1:0] act, input logic [31:0] val,
                           input logic [AW-1:0] lo, input logic [AW-1:0] hi,
                           input logic typed, input answer_t typed_ans);
    answer_t ans;
    int      gap;
    start           <= 1'b1;
    action_i        <= act;
    element_value_i <= val;
    left_index_i    <= lo;
    right_index_i   <= hi;
    do @(posedge clk_i); while (busy);
    if (predict_answer(act, val, lo, hi, ans))
      pending_answers = {pending_answers, (typed ? typed_ans : ans)};
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && strobe_o) begin
      results_checked++;
      if (pending_answers.size() == 0) begin
        if (fail_count < MAX_REPORTS)
          $display("%0t: unexpected result count=%0d status=%0d", $time,
                   distinct_count_o, status_o);
        fail_count++;
      end else begin
        want = pending_answers.pop_front();
        if (distinct_count_o !== want.count || status_o !== want.status) begin
          if (fail_count < MAX_REPORTS)
            $display("%0t: mismatch count exp=%0d got=%0d status exp=%0d got=%0d", $time,
                     want.count, distinct_count_o, want.status, status_o);
          fail_count++;
        end
      end
    end
  end

  initial begin
    stim_row_t     dir_rows [DIR_ROWS];
    logic [31:0]   pool [8];
    logic [31:0]   val;
    logic [AW-1:0] lo, hi;
    int            rand_items;
    int            n_ops, pool_size, r;
    logic          wild;

    dir_rows = '{
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_PAST}},
      '{ACT_QUERY,   32'h0000_0000, 10'd5,    10'd3,    1'b1, '{11'd0, ST_EMPTY}},
      '{ACT_QUERY,   32'hFFFF_FFFF, 10'd1023, 10'd0,    1'b1, '{11'd0, ST_EMPTY}},
      '{ACT_APPEND,  32'h8000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'h7FFF_FFFF, 10'd1023, 10'd1023, 1'b1, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'h0000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'hFFFF_FFFF, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'h8000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd4,    1'b0, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd1,    10'd4,    1'b0, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd0,    1'b1, '{11'd1, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd4,    10'd4,    1'b1, '{11'd1, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd5,    1'b1, '{11'd0, ST_PAST}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd1023, 1'b1, '{11'd0, ST_PAST}},
      '{ACT_QUERY,   32'h0000_0000, 10'd1023, 10'd1023, 1'b1, '{11'd0, ST_PAST}},
      '{ACT_UNUSED,  32'hFFFF_FFFF, 10'd1023, 10'd1023, 1'b1, '{11'd0, ST_OK}},
      '{ACT_RESTART, 32'h0000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd0,    1'b1, '{11'd0, ST_PAST}},
      '{ACT_APPEND,  32'h0000_0005, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'h0000_0005, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd1,    1'b0, '{11'd0, ST_OK}},
      '{ACT_APPEND,  32'hFFFF_FFFF, 10'd0,    10'd0,    1'b1, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd0,    10'd2,    1'b0, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd1,    10'd2,    1'b0, '{11'd0, ST_OK}},
      '{ACT_QUERY,   32'h0000_0000, 10'd2,    10'd1,    1'b1, '{11'd0, ST_EMPTY}}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DIR_ROWS; i++)
      send_item(dir_rows[i].act, dir_rows[i].val, dir_rows[i].lo, dir_rows[i].hi,
                dir_rows[i].typed, dir_rows[i].ans);

    // fill the whole store from a small pool to keep the match scans short
    send_item(ACT_RESTART, $urandom, '0, '0, 1'b0, '0);
    for (int i = 0; i < 4; i++) pool[i] = $urandom;
    for (int i = 0; i < DEPTH; i++)
      send_item(ACT_APPEND, pool[$urandom_range(0, 3)], AW'($urandom_range(0, 1023)),
                AW'($urandom_range(0, 1023)), 1'b1, '{11'd0, ST_OK});
    send_item(ACT_APPEND, $urandom, '0, '0, 1'b1, '{11'd0, ST_FULL});
    send_item(ACT_APPEND, pool[0], '0, '0, 1'b1, '{11'd0, ST_FULL});
    send_item(ACT_QUERY, '0, 10'd0, 10'd1023, 1'b0, '0);
    send_item(ACT_QUERY, '0, 10'd1023, 10'd1023, 1'b0, '0);
    for (int i = 0; i < 10; i++) begin
      hi = AW'($urandom_range(0, 1023));
      lo = (i < 5) ? AW'($urandom_range(hi > 8 ? hi - 8 : 0, hi)) : AW'($urandom_range(0, hi));
      send_item(ACT_QUERY, $urandom, lo, hi, 1'b0, '0);
    end

    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      n_ops     = ($urandom_range(0, 49) == 0) ? $urandom_range(100, 300) : $urandom_range(4, 40);
      pool_size = $urandom_range(1, 8);
      wild      = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 8; i++) begin
        case ($urandom_range(0, 7))
          0:       pool[i] = 32'h8000_0000;
          1:       pool[i] = 32'h7FFF_FFFF;
          2:       pool[i] = 32'hFFFF_FFFF;
          3:       pool[i] = 32'h0000_0000;
          default: pool[i] = $urandom;
        endcase
      end
      if ($urandom_range(0, 9) < 7) begin
        send_item(ACT_RESTART, $urandom, AW'($urandom_range(0, 1023)),
                  AW'($urandom_range(0, 1023)), 1'b0, '0);
        rand_items++;
      end
      for (int i = 0; i < n_ops; i++) begin
        r   = $urandom_range(0, 99);
        val = $urandom;
        lo  = AW'($urandom_range(0, 1023));
        hi  = AW'($urandom_range(0, 1023));
        if (r < 45) begin
          if (!wild) val = pool[$urandom_range(0, pool_size - 1)];
          send_item(ACT_APPEND, val, lo, hi, 1'b0, '0);
        end else if (r < 85) begin
          if (tb_loaded > 0) begin
            hi = AW'($urandom_range(0, tb_loaded - 1));
            lo = ($urandom_range(0, 3) == 0) ? hi : AW'($urandom_range(0, hi));
          end
          send_item(ACT_QUERY, val, lo, hi, 1'b0, '0);
        end else if (r < 89) begin
          lo = AW'($urandom_range(1, 1023));
          hi = AW'($urandom_range(0, lo - 1));
          send_item(ACT_QUERY, val, lo, hi, 1'b0, '0);
        end else if (r < 92) begin
          hi = (tb_loaded > 1023) ? 10'd1023 : AW'(tb_loaded);
          lo = AW'($urandom_range(0, hi));
          send_item(ACT_QUERY, val, lo, hi, 1'b0, '0);
        end else if (r < 96) begin
          send_item(ACT_QUERY, val, lo, hi, 1'b0, '0);
        end else if (r < 98) begin
          send_item(ACT_UNUSED, val, lo, hi, 1'b0, '0);
          continue;
        end else begin
          send_item(ACT_RESTART, val, lo, hi, 1'b0, '0);
        end
        rand_items++;
      end
    end

    start <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Run covered %0d stored appends, %0d appends to a full store, %0d restarts,",
             n_appends, n_full, n_restarts);
    $display("%0d counted queries, %0d empty ranges, %0d past-length queries; %0d results seen",
             n_counted, n_empty, n_past, results_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d failures", fail_count);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
